>>> rtl/gha_pkg.sv
// shared types and constants of the generational handle allocator
package gha_pkg;

  // slot table geometry
  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned GEN_W      = 8;
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int unsigned ENTRY_W    = 1 + GEN_W + IDX_W;

  // field widths of the words
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned STAT_W = 2;

  // configuration port
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;

  // reset values of the configuration registers
  localparam logic [GEN_W-1:0] GEN_LIMIT_RST = 8'd255;
  localparam logic [IDX_W-1:0] NULL_IDX_RST  = 10'd1023;

  // the last code changes no state but still gets an ok response
  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_NOT_LIVE  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GEN_LIMIT = 1'b0,
    CFG_NULL_IDX  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic issue;   // capture request word and read slot table
    logic commit;  // apply the update and load the response register
  } cmd_t;

endpackage

>>> rtl/gha_req_if.sv
// request channel: action and handle
interface gha_req_if import gha_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [IDX_W-1:0]     handle_index;
  logic [GEN_W-1:0]     handle_generation;

  modport source (output valid, action, handle_index, handle_generation, input ready);
  modport sink   (input valid, action, handle_index, handle_generation, output ready);
endinterface

>>> rtl/gha_rsp_if.sv
// response channel: allocated handle, status and live count
interface gha_rsp_if import gha_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     out_index;
  logic [GEN_W-1:0]     out_generation;
  logic [STAT_W-1:0]    status;
  logic                 is_live;
  logic [CNT_W-1:0]     live_count;

  modport source (output valid, out_index, out_generation, status, is_live, live_count,
                  input ready);
  modport sink   (input valid, out_index, out_generation, status, is_live, live_count,
                  output ready);
endinterface

>>> rtl/gha_ctrl.sv
// controller: request acceptance, execute step and response valid
module gha_ctrl import gha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  // state and response valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.issue = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait here while the previous word still sits in the response register
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.commit = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

>>> rtl/gha_dp.sv
// datapath: slot table memory, free list, counters and response register
module gha_dp import gha_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [ACT_W-1:0]     action_i,
  input  logic [IDX_W-1:0]     handle_index_i,
  input  logic [GEN_W-1:0]     handle_generation_i,
  output logic [IDX_W-1:0]     out_index_o,
  output logic [GEN_W-1:0]     out_generation_o,
  output logic [STAT_W-1:0]    status_o,
  output logic                 is_live_o,
  output logic [CNT_W-1:0]     live_count_o
);

  // slot table: {active, generation, link}; entries at or above the fresh
  // mark were never written and read as their reset contents
  logic [ENTRY_W-1:0] mem_q [SLOT_COUNT];
  logic [ENTRY_W-1:0] rdata_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   rd_addr;

  // configuration registers
  logic [GEN_W-1:0] gen_limit_q;
  logic [IDX_W-1:0] null_idx_q;

  // control state
  logic [IDX_W-1:0] free_head_q, free_head_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;
  logic [CNT_W-1:0] active_q, active_d;
  logic [CNT_W-1:0] avail_q, avail_d;

  // captured request word
  logic [ACT_W-1:0] act_q;
  logic [IDX_W-1:0] addr_q;
  logic [GEN_W-1:0] hgen_q;
  logic             fresh_hit_q;

  // response register
  logic [IDX_W-1:0]  out_index_q, out_index_d;
  logic [GEN_W-1:0]  out_gen_q, out_gen_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              is_live_q, is_live_d;
  logic [CNT_W-1:0]  live_count_q;

  // decoded entry
  logic             ent_active;
  logic [GEN_W-1:0] ent_gen;
  logic [IDX_W-1:0] ent_link;
  logic [IDX_W-1:0] fresh_link;
  logic             live;
  logic             reuse;
  logic [GEN_W:0]   gen_biased;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_limit_q <= GEN_LIMIT_RST;
      null_idx_q  <= NULL_IDX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_GEN_LIMIT: gen_limit_q <= cfg_data_i[GEN_W-1:0];
        CFG_NULL_IDX:  null_idx_q  <= cfg_data_i[IDX_W-1:0];
        default:       gen_limit_q <= gen_limit_q;
      endcase
    end
  end

  // read address: allocate reads the free head, the others the handle slot
  assign rd_addr = (action_i == ACT_ALLOC) ? free_head_q : handle_index_i;

  // slot table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      act_q       <= action_i;
      addr_q      <= rd_addr;
      hgen_q      <= handle_generation_i;
      fresh_hit_q <= ({1'b0, rd_addr} >= fresh_q);
    end
  end

  // entry decode with unwritten slots at their reset contents
  assign fresh_link = (addr_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : addr_q + 1'b1;
  assign ent_active = fresh_hit_q ? 1'b0 : rdata_q[ENTRY_W-1];
  assign ent_gen    = fresh_hit_q ? '0 : rdata_q[IDX_W +: GEN_W];
  assign ent_link   = fresh_hit_q ? fresh_link : rdata_q[IDX_W-1:0];

  // live test; the index field cannot exceed the table
  assign live       = ent_active && (ent_gen == hgen_q);
  // retirement test, with the null slot one generation early
  assign gen_biased = {1'b0, ent_gen} + {{GEN_W{1'b0}}, (addr_q == null_idx_q)};
  assign reuse      = gen_biased < {1'b0, gen_limit_q};

  // execute step
  always_comb begin
    free_head_d = free_head_q;
    fresh_d     = fresh_q;
    active_d    = active_q;
    avail_d     = avail_q;
    out_index_d = '0;
    out_gen_d   = '0;
    status_d    = STAT_OK;
    is_live_d   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = {1'b0, ent_gen, ent_link};
    case (act_q)
      ACT_ALLOC: begin
        if (avail_q == '0) begin
          status_d = STAT_EXHAUSTED;
        end else begin
          out_index_d = addr_q;
          out_gen_d   = ent_gen;
          free_head_d = ent_link;
          active_d    = active_q + 1'b1;
          avail_d     = avail_q - 1'b1;
          mem_we      = 1'b1;
          mem_wdata   = {1'b1, ent_gen, ent_link};
          if (fresh_hit_q) begin
            fresh_d = fresh_q + 1'b1;
          end
        end
      end
      ACT_RELEASE: begin
        if (!live) begin
          status_d = STAT_NOT_LIVE;
        end else begin
          active_d = active_q - 1'b1;
          mem_we   = 1'b1;
          if (reuse) begin
            mem_wdata   = {1'b0, ent_gen + 1'b1, free_head_q};
            free_head_d = addr_q;
            avail_d     = avail_q + 1'b1;
          end
        end
      end
      ACT_QUERY: begin
        if (live) begin
          is_live_d = 1'b1;
        end else begin
          status_d = STAT_NOT_LIVE;
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
    if (!cmd_i.commit) begin
      mem_we = 1'b0;
    end
  end

  // free list and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      fresh_q     <= '0;
      active_q    <= '0;
      avail_q     <= CNT_W'(SLOT_COUNT);
    end else if (cmd_i.commit) begin
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      active_q    <= active_d;
      avail_q     <= avail_d;
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_index_q  <= out_index_d;
      out_gen_q    <= out_gen_d;
      status_q     <= status_d;
      is_live_q    <= is_live_d;
      live_count_q <= active_d;
    end
  end

  assign out_index_o      = out_index_q;
  assign out_generation_o = out_gen_q;
  assign status_o         = status_q;
  assign is_live_o        = is_live_q;
  assign live_count_o     = live_count_q;

endmodule

>>> rtl/generational_handle_allocator.sv
// top level of the generational handle allocator
//
//   channel  direction  handshake            word
//   req      in         req.valid/req.ready  action, handle_index, handle_generation
//   rsp      out        rsp.valid/rsp.ready  out_index, out_generation, status,
//                                            is_live, live_count
//   cfg      in         cfg_we_i             cfg_idx_i, cfg_data_i
//
// each request takes two steps: a read of the slot table (single-port synchronous
// memory, registered read), then an update of it and a load of the response
// register. no clearing pass after reset: a fresh mark tracks the slots never
// written, so the block takes requests as soon as reset is released.
// a response word waiting on rsp holds the execute step until it is taken.
module generational_handle_allocator import gha_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  gha_req_if.sink              req,
  gha_rsp_if.source            rsp
);

  cmd_t cmd;

  // controller
  gha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  // datapath
  gha_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .action_i            (req.action),
    .handle_index_i      (req.handle_index),
    .handle_generation_i (req.handle_generation),
    .out_index_o         (rsp.out_index),
    .out_generation_o    (rsp.out_generation),
    .status_o            (rsp.status),
    .is_live_o           (rsp.is_live),
    .live_count_o        (rsp.live_count)
  );

  // a read is always followed by its execute step, never by another read
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.issue |=> !cmd.issue)
    else $error("slot table read issued twice without execute");

  // a committed step shows up on the response channel
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.commit |=> rsp.valid)
    else $error("committed step produced no response word");

  // exhausted pool hands out no handle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.status == STAT_EXHAUSTED) |->
      (rsp.out_index == '0 && rsp.out_generation == '0 && !rsp.is_live))
    else $error("handle returned with exhausted status");

  // a live answer always carries ok status and the live count never exceeds the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> ((!rsp.is_live || rsp.status == STAT_OK) &&
                   rsp.live_count <= CNT_W'(SLOT_COUNT)))
    else $error("inconsistent live answer or live count");

endmodule
